FILE: src/tcdma_pkg.sv
// Shared types, codes and helpers of the two-channel DMA register engine.
`default_nettype none
package tcdma_pkg;

	// Request kinds carried on the input tuser
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BLOCKED  = 2'd1;
	localparam logic [1:0] ST_ADDR_ERR = 2'd2;

	// Register index within a channel (offset bits 3:2)
	localparam logic [1:0] REG_SRC   = 2'd0;
	localparam logic [1:0] REG_DST   = 2'd1;
	localparam logic [1:0] REG_SIZE  = 2'd2;
	localparam logic [1:0] REG_START = 2'd3;

	localparam logic [7:0]  LAST_REG_OFFSET = 8'h1C;
	localparam logic [31:0] START_GO        = 32'h1;

	// Command from the request decoder to one channel
	typedef struct packed {
		logic        tick;
		logic        wr_en;
		logic [1:0]  reg_sel;
		logic [31:0] wdata;
		logic [31:0] mask;
	} cmd_t;

	// Channel status: current registers plus this step's move and irq
	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] size;
		logic [31:0] start;
		logic        busy;
		logic        irq_d;
		logic        mv;
		logic [31:0] ms;
		logic [31:0] mt;
		logic [2:0]  ml;
	} chan_t;

	// One result item
	typedef struct packed {
		logic        last;
		logic        channel;
		logic        irq_one;
		logic        irq_zero;
		logic [2:0]  move_length;
		logic [31:0] move_target;
		logic [31:0] move_source;
		logic        move_valid;
		logic [1:0]  status;
		logic [31:0] read_data;
	} res_t;

	// Little-endian byte-enable mask for an access length; 5..7 act as 4
	function automatic logic [31:0] byte_mask(input logic [2:0] len);
		logic [31:0] m;
		unique case (len)
			3'd0: m = 32'h0000_0000;
			3'd1: m = 32'h0000_00FF;
			3'd2: m = 32'h0000_FFFF;
			3'd3: m = 32'h00FF_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

FILE: src/two_channel_dma_register_engine_top.sv
// Top level of the two-channel DMA register engine.
// Usage:
//   Input stream (s_axis_*): tuser holds the request kind (tick, register read,
//   register write); tdata holds offset, write data and access length.
//   Output stream (m_axis_*): one item per read or write, two per tick
//   (channel zero, then channel one with tlast set). tuser is the channel of
//   tick items and zero on others. Results enter the output register at
//   acceptance. Reads and writes sustain one item per cycle when the output is
//   not stalled; a tick's second result waits in a one-entry holding register
//   and the input is held off until it has moved to the output register.
//   Register and step updates happen at acceptance, in a single pass of
//   combinational logic from the channel registers to the result register.
//   A stall on m_axis_tready holds the output item steady; the input keeps
//   accepting as long as the output register is freed in the same cycle.
//   Reset (arst_n low) clears all channel registers, locks and interrupts and
//   empties the output side.
`default_nettype none
module two_channel_dma_register_engine_top #(
	parameter int CHUNK_BYTES = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [7:0] reg_offset, [39:8] write_data, [42:40] access_len, [47:43] zero
	input  wire logic [47:0]  s_axis_tdata,
	// [1:0] req_type
	input  wire logic [1:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [31:0] read_data, [33:32] status, [34] move_valid, [66:35] move_source,
	// [98:67] move_target, [101:99] move_length, [102] irq_zero, [103] irq_one
	output logic [103:0]      m_axis_tdata,
	// [0] channel
	output logic [0:0]        m_axis_tuser,
	output logic              m_axis_tlast
);

	logic [1:0]  req;
	logic [7:0]  off;
	logic [31:0] wdata;
	logic [31:0] mask;
	logic        mapped, ch, blocked, acc;
	logic [1:0]  rsel;

	tcdma_pkg::cmd_t  cmd  [2];
	tcdma_pkg::chan_t chan [2];
	tcdma_pkg::res_t  res0, res1;
	tcdma_pkg::res_t  out_q, pend_q;
	logic             out_valid_q, pend_valid_q;
	logic             out_free;

	assign req     = s_axis_tuser;
	assign off     = s_axis_tdata[7:0];
	assign wdata   = s_axis_tdata[39:8];
	assign mask    = tcdma_pkg::byte_mask(s_axis_tdata[42:40]);
	assign mapped  = (off[1:0] == 2'b00) && (off <= tcdma_pkg::LAST_REG_OFFSET);
	assign ch      = off[4];
	assign rsel    = off[3:2];
	assign blocked = (rsel != tcdma_pkg::REG_START) && chan[ch].busy;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !pend_valid_q && out_free;
	assign acc           = s_axis_tvalid && s_axis_tready;

	for (genvar c = 0; c < 2; c++) begin : g_chan
		assign cmd[c].tick    = acc && (req == tcdma_pkg::REQ_TICK);
		assign cmd[c].wr_en   = acc && (req == tcdma_pkg::REQ_WRITE) && mapped
			&& (ch == 1'(c)) && !blocked;
		assign cmd[c].reg_sel = rsel;
		assign cmd[c].wdata   = wdata;
		assign cmd[c].mask    = mask;

		tcdma_channel #(
			.CHUNK_BYTES(CHUNK_BYTES)
		) u_chan (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd[c]),
			.st    (chan[c])
		);
	end

	// Build the result items for the item being accepted
	always_comb begin
		logic [31:0] rd;
		rd = '0;
		unique case (rsel)
			tcdma_pkg::REG_SRC:  rd = chan[ch].src;
			tcdma_pkg::REG_DST:  rd = chan[ch].dst;
			tcdma_pkg::REG_SIZE: rd = chan[ch].size;
			default:             rd = chan[ch].start;
		endcase

		res0          = '0;
		res0.irq_zero = chan[0].irq_d;
		res0.irq_one  = chan[1].irq_d;
		res1          = res0;
		res1.channel  = 1'b1;
		res1.last     = 1'b1;
		res1.move_valid  = chan[1].mv;
		res1.move_source = chan[1].ms;
		res1.move_target = chan[1].mt;
		res1.move_length = chan[1].ml;

		unique case (req)
			tcdma_pkg::REQ_TICK: begin
				res0.move_valid  = chan[0].mv;
				res0.move_source = chan[0].ms;
				res0.move_target = chan[0].mt;
				res0.move_length = chan[0].ml;
			end
			tcdma_pkg::REQ_READ: begin
				res0.last      = 1'b1;
				res0.read_data = mapped ? (rd & mask) : '0;
			end
			tcdma_pkg::REQ_WRITE: begin
				res0.last = 1'b1;
				if (!mapped) begin
					res0.status = tcdma_pkg::ST_ADDR_ERR;
				end else if (blocked) begin
					res0.status = tcdma_pkg::ST_BLOCKED;
				end
			end
			default: begin
				res0.last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= (req == tcdma_pkg::REQ_TICK);
			end else if (pend_valid_q && out_free) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			out_q  <= res0;
			pend_q <= res1;
		end else if (pend_valid_q && out_free) begin
			out_q <= pend_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.irq_one, out_q.irq_zero, out_q.move_length,
		out_q.move_target, out_q.move_source, out_q.move_valid, out_q.status,
		out_q.read_data};
	assign m_axis_tuser  = out_q.channel;
	assign m_axis_tlast  = out_q.last;

endmodule
`default_nettype wire

FILE: src/tcdma_channel.sv
// One DMA channel: its four bus registers, busy lock, interrupt and tick step.
`default_nettype none
module tcdma_channel #(
	parameter int CHUNK_BYTES = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tcdma_pkg::cmd_t   cmd,
	output tcdma_pkg::chan_t       st
);

	localparam logic [31:0] CHUNK = 32'(CHUNK_BYTES);

	logic [31:0] src_q, dst_q, size_q, start_q;
	logic        busy_q, irq_q;
	logic [31:0] src_d, dst_d, size_d, start_d;
	logic        busy_d, irq_d;
	logic        mv;
	logic [31:0] ml_full;

	always_comb begin
		src_d   = src_q;
		dst_d   = dst_q;
		size_d  = size_q;
		start_d = start_q;
		busy_d  = busy_q;
		irq_d   = irq_q;
		mv      = 1'b0;
		ml_full = '0;
		if (cmd.tick) begin
			if (start_q != '0) begin
				if (size_q != '0) begin
					mv      = 1'b1;
					ml_full = (size_q >= CHUNK) ? CHUNK : size_q;
					if (size_q > CHUNK) begin
						src_d  = src_q + CHUNK;
						dst_d  = dst_q + CHUNK;
						size_d = size_q - CHUNK;
					end else begin
						size_d = '0;
					end
				end else begin
					irq_d = 1'b1;
				end
			end else begin
				busy_d = 1'b0;
				irq_d  = 1'b0;
			end
		end else if (cmd.wr_en) begin
			unique case (cmd.reg_sel)
				tcdma_pkg::REG_SRC:  src_d  = (src_q & ~cmd.mask) | (cmd.wdata & cmd.mask);
				tcdma_pkg::REG_DST:  dst_d  = (dst_q & ~cmd.mask) | (cmd.wdata & cmd.mask);
				tcdma_pkg::REG_SIZE: size_d = (size_q & ~cmd.mask) | (cmd.wdata & cmd.mask);
				default: begin
					start_d = (start_q & ~cmd.mask) | (cmd.wdata & cmd.mask);
					busy_d  = (start_d == tcdma_pkg::START_GO);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q   <= '0;
			dst_q   <= '0;
			size_q  <= '0;
			start_q <= '0;
			busy_q  <= 1'b0;
			irq_q   <= 1'b0;
		end else begin
			src_q   <= src_d;
			dst_q   <= dst_d;
			size_q  <= size_d;
			start_q <= start_d;
			busy_q  <= busy_d;
			irq_q   <= irq_d;
		end
	end

	assign st.src   = src_q;
	assign st.dst   = dst_q;
	assign st.size  = size_q;
	assign st.start = start_q;
	assign st.busy  = busy_q;
	assign st.irq_d = irq_d;
	assign st.mv    = mv;
	assign st.ms    = mv ? src_q : '0;
	assign st.mt    = mv ? dst_q : '0;
	assign st.ml    = ml_full[2:0];

endmodule
`default_nettype wire

FILE: verif/two_channel_dma_register_engine_top_tb.sv
// Self-checking testbench for the two-channel DMA register engine.
`timescale 1ns / 1ps

class dma_scoreboard;
	localparam int CHUNK_BYTES = 4;

	logic [31:0]       chan_reg [2][4];
	bit                busy [2];
	bit                irq [2];
	tcdma_pkg::res_t   pending_results [$];
	int                errors;

	function new();
		for (int c = 0; c < 2; c++) begin
			for (int r = 0; r < 4; r++)
				chan_reg[c][r] = '0;
			busy[c] = 1'b0;
			irq[c] = 1'b0;
		end
		errors = 0;
	endfunction

	function logic [31:0] lane_mask(logic [2:0] len);
		if (len == 3'd0)
			return 32'h0;
		if (len >= 3'd4)
			return '1;
		return (32'h1 << (8 * len)) - 32'h1;
	endfunction

	function void push_tick();
		logic            mv [2];
		logic [31:0]     ms [2];
		logic [31:0]     mt [2];
		logic [2:0]      ml [2];
		tcdma_pkg::res_t r;
		for (int c = 0; c < 2; c++) begin
			mv[c] = 1'b0;
			ms[c] = '0;
			mt[c] = '0;
			ml[c] = '0;
			if (chan_reg[c][tcdma_pkg::REG_START] != 32'h0) begin
				if (chan_reg[c][tcdma_pkg::REG_SIZE] != 32'h0) begin
					mv[c] = 1'b1;
					ms[c] = chan_reg[c][tcdma_pkg::REG_SRC];
					mt[c] = chan_reg[c][tcdma_pkg::REG_DST];
					ml[c] = (chan_reg[c][tcdma_pkg::REG_SIZE] >= CHUNK_BYTES)
						? 3'(CHUNK_BYTES) : chan_reg[c][tcdma_pkg::REG_SIZE][2:0];
					if (chan_reg[c][tcdma_pkg::REG_SIZE] > CHUNK_BYTES) begin
						chan_reg[c][tcdma_pkg::REG_SRC] += CHUNK_BYTES;
						chan_reg[c][tcdma_pkg::REG_DST] += CHUNK_BYTES;
						chan_reg[c][tcdma_pkg::REG_SIZE] -= CHUNK_BYTES;
					end else begin
						chan_reg[c][tcdma_pkg::REG_SIZE] = '0;
					end
				end else begin
					// drained channel: interrupt only on a tick without a move
					irq[c] = 1'b1;
				end
			end else begin
				busy[c] = 1'b0;
				irq[c] = 1'b0;
			end
		end
		// both results carry the irq lines after the whole step
		for (int c = 0; c < 2; c++) begin
			r = '0;
			r.channel = c[0];
			r.move_valid = mv[c];
			r.move_source = ms[c];
			r.move_target = mt[c];
			r.move_length = ml[c];
			r.irq_zero = irq[0];
			r.irq_one = irq[1];
			r.last = (c == 1);
			pending_results.push_back(r);
		end
	endfunction

	function void note_request(logic [1:0] req, logic [7:0] off, logic [31:0] data,
		logic [2:0] len);
		logic            mapped;
		logic            ch;
		logic [1:0]      idx;
		logic [31:0]     m;
		tcdma_pkg::res_t r;
		if (req == tcdma_pkg::REQ_TICK) begin
			push_tick();
			return;
		end
		mapped = (off[1:0] == 2'b00) && (off <= tcdma_pkg::LAST_REG_OFFSET);
		ch = off[4];
		idx = off[3:2];
		m = lane_mask(len);
		r = '0;
		if (req == tcdma_pkg::REQ_READ) begin
			if (mapped)
				r.read_data = chan_reg[ch][idx] & m;
		end else if (req == tcdma_pkg::REQ_WRITE) begin
			if (!mapped) begin
				r.status = tcdma_pkg::ST_ADDR_ERR;
			end else if (idx != tcdma_pkg::REG_START && busy[ch]) begin
				r.status = tcdma_pkg::ST_BLOCKED;
			end else begin
				chan_reg[ch][idx] = (chan_reg[ch][idx] & ~m) | (data & m);
				if (idx == tcdma_pkg::REG_START)
					busy[ch] = (chan_reg[ch][idx] == tcdma_pkg::START_GO);
			end
		end
		r.irq_zero = irq[0];
		r.irq_one = irq[1];
		r.last = 1'b1;
		pending_results.push_back(r);
	endfunction

	function void compare(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	function void check_result(tcdma_pkg::res_t got);
		tcdma_pkg::res_t want;
		if (pending_results.size() == 0) begin
			$error("result item with nothing expected: 0x%0h", got);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		compare("read_data", want.read_data, got.read_data);
		compare("status", 32'(want.status), 32'(got.status));
		compare("channel", 32'(want.channel), 32'(got.channel));
		compare("move_valid", 32'(want.move_valid), 32'(got.move_valid));
		compare("move_source", want.move_source, got.move_source);
		compare("move_target", want.move_target, got.move_target);
		compare("move_length", 32'(want.move_length), 32'(got.move_length));
		compare("irq_zero", 32'(want.irq_zero), 32'(got.irq_zero));
		compare("irq_one", 32'(want.irq_one), 32'(got.irq_one));
		compare("last", 32'(want.last), 32'(got.last));
	endfunction
endclass

module two_channel_dma_register_engine_top_tb;
	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int NUM_ITEMS = 1500;
	localparam int STALL_LIMIT = 500;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [47:0]  s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = tcdma_pkg::REQ_TICK;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;
	logic [0:0]   m_axis_tuser;
	logic         m_axis_tlast;

	dma_scoreboard sb;
	int            sent = 0;
	int            quiet_cycles = 0;
	bit            calm = 1'b0;

	two_channel_dma_register_engine_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 29);

	// tlast, tuser and tdata line up with the packed result struct
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result({m_axis_tlast, m_axis_tuser[0], m_axis_tdata});
			if (s_axis_tvalid && s_axis_tready)
				sb.note_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[39:8],
					s_axis_tdata[42:40]);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic send(input logic [1:0] req, input logic [7:0] off,
		input logic [31:0] data, input logic [2:0] len);
		calm = (sent >= 600) && (sent < 900);
		while (!calm && $urandom_range(0, 99) < 29) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, len, data, off};
		s_axis_tuser <= req;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sent++;
	endtask

	function automatic logic [7:0] reg_offset(int c, logic [1:0] idx);
		return {3'b000, c[0], idx, 2'b00};
	endfunction

	function automatic logic [2:0] pick_len();
		if ($urandom_range(0, 99) < 80)
			return 3'd4;
		return 3'($urandom_range(0, 7));
	endfunction

	function automatic logic [31:0] pick_size();
		int p;
		p = $urandom_range(0, 99);
		if (p < 85)
			return $urandom_range(0, 24);
		if (p < 95)
			return $urandom_range(25, 200);
		return $urandom;
	endfunction

	// stop, program and start one channel, then let it run for a while
	task automatic program_run(input int c);
		logic [31:0] go;
		int          steps;
		int          p;
		p = $urandom_range(0, 99);
		go = (p < 80) ? tcdma_pkg::START_GO : $urandom;
		send(tcdma_pkg::REQ_WRITE, reg_offset(c, tcdma_pkg::REG_START), 32'h0, 3'd4);
		send(tcdma_pkg::REQ_WRITE, reg_offset(c, tcdma_pkg::REG_SRC), $urandom, pick_len());
		send(tcdma_pkg::REQ_WRITE, reg_offset(c, tcdma_pkg::REG_DST), $urandom, pick_len());
		send(tcdma_pkg::REQ_WRITE, reg_offset(c, tcdma_pkg::REG_SIZE), pick_size(),
			pick_len());
		send(tcdma_pkg::REQ_WRITE, reg_offset(c, tcdma_pkg::REG_START), go, pick_len());
		steps = $urandom_range(1, 12);
		for (int i = 0; i < steps; i++) begin
			p = $urandom_range(0, 99);
			if (p < 75)
				send(tcdma_pkg::REQ_TICK, 8'h00, 32'h0, 3'd0);
			else if (p < 90)
				send(tcdma_pkg::REQ_READ,
					reg_offset($urandom_range(0, 1), 2'($urandom_range(0, 3))),
					$urandom, pick_len());
			else
				send(tcdma_pkg::REQ_WRITE, reg_offset(c, 2'($urandom_range(0, 2))),
					$urandom, pick_len());
		end
		if ($urandom_range(0, 99) < 25)
			send(tcdma_pkg::REQ_WRITE, reg_offset(c, tcdma_pkg::REG_START), 32'h0,
				pick_len());
	endtask

	initial begin
		int p;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, wrap, blocking, unmapped offsets, odd lengths
		send(tcdma_pkg::REQ_READ, 8'h00, 32'h0, 3'd4);
		send(tcdma_pkg::REQ_WRITE, 8'h00, 32'hFFFF_FFFC, 3'd4);
		send(tcdma_pkg::REQ_WRITE, 8'h04, 32'hFFFF_FFFF, 3'd7);
		send(tcdma_pkg::REQ_WRITE, 8'h08, 32'h0000_0009, 3'd1);
		send(tcdma_pkg::REQ_WRITE, 8'h0C, tcdma_pkg::START_GO, 3'd4);
		send(tcdma_pkg::REQ_WRITE, 8'h00, 32'h0, 3'd4);
		send(tcdma_pkg::REQ_WRITE, 8'h02, 32'hA5A5_A5A5, 3'd4);
		send(tcdma_pkg::REQ_READ, 8'hFF, 32'h0, 3'd4);
		send(tcdma_pkg::REQ_TICK, 8'h00, 32'h0, 3'd0);
		send(tcdma_pkg::REQ_TICK, 8'h00, 32'h0, 3'd0);
		send(tcdma_pkg::REQ_TICK, 8'h00, 32'h0, 3'd0);
		send(tcdma_pkg::REQ_TICK, 8'h00, 32'h0, 3'd0);
		send(tcdma_pkg::REQ_READ, 8'h08, 32'h0, 3'd0);
		send(REQ_NONE, 8'hFF, 32'hFFFF_FFFF, 3'd7);
		send(tcdma_pkg::REQ_WRITE, 8'h1C, 32'h0000_0102, 3'd2);
		send(tcdma_pkg::REQ_WRITE, 8'h18, 32'hFFFF_FFFF, 3'd3);
		send(tcdma_pkg::REQ_TICK, 8'h00, 32'h0, 3'd0);
		send(tcdma_pkg::REQ_WRITE, 8'h0C, 32'h0, 3'd1);
		send(tcdma_pkg::REQ_TICK, 8'h00, 32'h0, 3'd0);
		send(tcdma_pkg::REQ_READ, 8'h14, 32'h0, 3'd2);
		send(tcdma_pkg::REQ_WRITE, 8'h20, 32'h1234_5678, 3'd4);
		send(tcdma_pkg::REQ_READ, 8'h1C, 32'h0, 3'd5);
		send(tcdma_pkg::REQ_WRITE, 8'h1C, 32'h0, 3'd4);
		send(tcdma_pkg::REQ_TICK, 8'h00, 32'h0, 3'd0);

		while (sent < NUM_ITEMS) begin
			p = $urandom_range(0, 99);
			if (p < 60)
				program_run($urandom_range(0, 1));
			else if (p < 85)
				send(($urandom_range(0, 99) < 70) ? tcdma_pkg::REQ_TICK
					: tcdma_pkg::REQ_READ,
					8'($urandom_range(0, 255)), $urandom, 3'($urandom_range(0, 7)));
			else
				send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom,
					3'($urandom_range(0, 7)));
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

FILE: sim.f
src/tcdma_pkg.sv
src/tcdma_channel.sv
src/two_channel_dma_register_engine_top.sv
verif/two_channel_dma_register_engine_top_tb.sv
